[hw/rtl/assert_macros.svh]
// Assertion macros shared by the convolution RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[hw/rtl/cwc_pkg.sv]
// Shared types, constants and helpers for the clamped window convolution.
// Depends on nothing.
package cwc_pkg;
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int MAX_DIM    = 7;
    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int YW   = $clog2(MAX_HEIGHT);
    localparam int PIX_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int PAW  = $clog2(PIX_DEPTH);
    localparam int COEF_DEPTH = MAX_DIM * MAX_DIM;
    localparam int CAW  = $clog2(COEF_DEPTH);
    localparam int DW   = $clog2(MAX_DIM + 1);
    localparam int ACCW = 40;
    localparam int CSW  = 24;
    localparam int QW   = 48;
    localparam int CSUM_MIN = 52;

    localparam logic [1:0] CMD_PIX  = 2'd0;
    localparam logic [1:0] CMD_COEF = 2'd1;
    localparam logic [1:0] CMD_COMP = 2'd2;
    localparam logic [1:0] CMD_RSVD = 2'd3;   // unused, ignored

    // configuration register byte addresses
    localparam logic [3:0] REG_WIDTH  = 4'h0;
    localparam logic [3:0] REG_HEIGHT = 4'h4;
    localparam logic [3:0] REG_KDIM   = 4'h8;
    localparam logic [3:0] REG_AVG    = 4'hC;

    typedef struct packed {
        logic start;        // load request and begin a window pass
        logic next_tap;     // advance window counters
        logic accumulate;   // add returned sample
        logic div_start;    // begin rounding division
        logic div_step;     // one quotient bit
        logic finish;       // latch result
    } t_dp_cmd;

    typedef struct packed {
        logic last_tap;
        logic div_done;
    } t_dp_sts;

    // Effective odd kernel side, at least three, capped at the maximum.
    function automatic logic [DW-1:0] eff_dim(input logic [2:0] k);
        logic [DW:0] d;
        d = {{(DW-2){1'b0}}, k};
        if (!d[0]) d = d + 1'b1;
        if (d < 3) d = 3;
        if (d > MAX_DIM) d = (MAX_DIM % 2 != 0) ? (DW+1)'(MAX_DIM) : (DW+1)'(MAX_DIM - 1);
        return d[DW-1:0];
    endfunction
endpackage

[hw/rtl/cwc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module cwc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

[hw/rtl/cwc_datapath.sv]
// Datapath: stores, window address generation, MAC, rounding divider.
// Depends on cwc_pkg and cwc_ram.
module cwc_datapath import cwc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    // store writes
    input  logic              i_pix_we,
    input  logic              i_coef_we,
    input  logic [XW-1:0]     i_pos_x,
    input  logic [YW-1:0]     i_pos_y,
    input  logic [5:0]        i_coef_index,
    input  logic [15:0]       i_value,
    // configuration
    input  logic [8:0]        i_width,
    input  logic [8:0]        i_height,
    input  logic [2:0]        i_kdim,
    input  logic              i_avg,
    output logic [15:0]       o_filtered
);
    // request registers
    logic [XW-1:0] r_px;
    logic [YW-1:0] r_py;
    logic [DW-1:0] r_dim, r_row, r_col;
    logic [9:0]    r_wm1, r_hm1;
    logic          r_avg;
    logic          r_val;            // a read issued last cycle returns now
    logic [DW-1:0] r_vrow, r_vcol;
    logic signed [ACCW-1:0] r_acc;
    logic signed [CSW-1:0]  r_csum;
    logic signed [16:0]     r_prod_p;
    logic signed [15:0]     r_prod_k;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_px  <= i_pos_x;
            r_py  <= i_pos_y;
            r_dim <= eff_dim(i_kdim);
            r_avg <= i_avg;
            r_wm1 <= (i_width > 9'(MAX_WIDTH) ? 10'(MAX_WIDTH) : {1'b0, i_width}) - 10'd1;
            r_hm1 <= (i_height > 9'(MAX_HEIGHT) ? 10'(MAX_HEIGHT) : {1'b0, i_height}) - 10'd1;
            r_row <= '0;
            r_col <= '0;
        end else if (i_cmd.next_tap) begin
            if (r_col == r_dim - 1'b1) begin
                r_col <= '0;
                r_row <= r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end
    assign o_sts.last_tap = (r_col == r_dim - 1'b1) && (r_row == r_dim - 1'b1);

    // clamped window coordinates
    logic signed [11:0] sx, sy;
    logic [XW-1:0] cx;
    logic [YW-1:0] cy;
    logic [CAW-1:0] cidx;
    always_comb begin
        sx = $signed({4'b0, r_px}) + $signed({9'b0, r_col}) - $signed({9'b0, r_dim >> 1});
        sy = $signed({4'b0, r_py}) + $signed({9'b0, r_row}) - $signed({9'b0, r_dim >> 1});
        if (sx < 0) cx = '0;
        else if (sx > $signed({2'b0, r_wm1})) cx = r_wm1[XW-1:0];
        else cx = sx[XW-1:0];
        if (sy < 0) cy = '0;
        else if (sy > $signed({2'b0, r_hm1})) cy = r_hm1[YW-1:0];
        else cy = sy[YW-1:0];
        cidx = CAW'({3'b0, r_row} * {3'b0, r_dim} + {3'b0, r_col});
    end

    logic [15:0] pix_q, coef_q;
    cwc_ram #(.WIDTH(16), .DEPTH(PIX_DEPTH)) u_pix (
        .i_clk(i_clk), .i_we(i_pix_we), .i_waddr({i_pos_y, i_pos_x}),
        .i_wdata(i_value), .i_raddr({cy, cx}), .o_rdata(pix_q));
    cwc_ram #(.WIDTH(16), .DEPTH(COEF_DEPTH)) u_coef (
        .i_clk(i_clk), .i_we(i_coef_we), .i_waddr(i_coef_index[CAW-1:0]),
        .i_wdata(i_value), .i_raddr(cidx), .o_rdata(coef_q));

    // two-stage MAC: register operands, then multiply and accumulate
    logic r_mac;
    logic signed [31:0] prod;
    assign prod = r_prod_p * r_prod_k;
    always_ff @(posedge i_clk) begin
        r_val <= i_cmd.accumulate;
        r_mac <= r_val;
        if (r_val) begin
            r_prod_p <= $signed({pix_q[15], pix_q});
            r_prod_k <= r_avg ? 16'sd1 : $signed(coef_q);
        end
        if (i_cmd.start) begin
            r_acc  <= '0;
            r_csum <= '0;
        end else if (r_mac) begin
            r_acc  <= r_acc + ACCW'(prod);
            r_csum <= r_csum + CSW'(r_prod_k);
        end
    end

    // restoring divider on magnitudes: q = (2|n| + d) / (2d)
    logic [QW-1:0] r_num, r_rem;
    logic [QW-1:0] r_den;
    logic          r_neg, r_bypass;
    logic [5:0]    r_cnt;
    logic signed [ACCW-1:0] tq, ntr;
    logic [ACCW-1:0] mag;
    logic [CSW-1:0]  dmag;
    logic [QW:0] trial;
    always_comb begin
        tq  = (r_acc < 0) ? -((-r_acc) >>> 8) : (r_acc >>> 8);
        ntr = r_avg ? r_acc : (tq <<< 8);
        mag = ntr[ACCW-1] ? ACCW'(-ntr) : ACCW'(ntr);
        dmag = r_avg ? CSW'({3'b0, r_dim} * {3'b0, r_dim}) : CSW'(r_csum);
        trial = {r_rem, r_num[QW-1]} - {1'b0, r_den};
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.div_start) begin
            r_neg    <= ntr[ACCW-1];
            r_bypass <= !r_avg && (r_csum < CSUM_MIN);
            r_num    <= QW'({mag, 1'b0}) + QW'(dmag);
            r_den    <= QW'({dmag, 1'b0});
            r_rem    <= '0;
            r_cnt    <= 6'(QW);
        end else if (i_cmd.div_step && r_cnt != 0) begin
            r_cnt <= r_cnt - 1'b1;
            if (!trial[QW]) begin
                r_rem <= trial[QW-1:0];
                r_num <= {r_num[QW-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[QW-2:0], r_num[QW-1]};
                r_num <= {r_num[QW-2:0], 1'b0};
            end
        end
    end
    assign o_sts.div_done = (r_cnt == 0);

    // signed result with saturation
    logic signed [QW:0] res;
    logic [15:0] r_out;
    always_comb begin
        if (r_bypass) res = (QW+1)'(tq);
        else res = r_neg ? -$signed({1'b0, r_num}) : $signed({1'b0, r_num});
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (res > 32767) r_out <= 16'h7fff;
            else if (res < -32768) r_out <= 16'h8000;
            else r_out <= res[15:0];
        end
    end
    assign o_filtered = r_out;
endmodule

[hw/rtl/cwc_ctrl.sv]
// Controller: sequences window reads, MAC drain, division and output.
// Depends on cwc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module cwc_ctrl import cwc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_go,        // compute accepted in range
    input  logic    i_oor,       // compute accepted, out of range
    input  t_dp_sts i_sts,
    input  logic    i_out_taken,
    output t_dp_cmd o_cmd,
    output logic    o_busy,
    output logic    o_out_valid,
    output logic    o_out_oor
);
    localparam logic [2:0] S_IDLE = 3'd0, S_READ = 3'd1, S_DRAIN = 3'd2,
                           S_DIVS = 3'd3, S_DIV = 3'd4, S_FIN = 3'd5, S_OUT = 3'd6;
    logic [2:0] r_state, n_state;
    logic [1:0] r_drain, n_drain;
    logic       r_oor, n_oor;

    always_comb begin
        n_state = r_state;
        n_drain = r_drain;
        n_oor   = r_oor;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    o_cmd.start = 1'b1;
                    n_state = S_READ;
                    n_oor = 1'b0;
                end else if (i_oor) begin
                    n_state = S_OUT;
                    n_oor = 1'b1;
                end
            end
            S_READ: begin
                o_cmd.accumulate = 1'b1;
                o_cmd.next_tap = 1'b1;
                if (i_sts.last_tap) begin
                    n_state = S_DRAIN;
                    n_drain = 2'd3;
                end
            end
            S_DRAIN: begin
                n_drain = r_drain - 1'b1;
                if (r_drain == 2'd1) n_state = S_DIVS;
            end
            S_DIVS: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_taken) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_drain <= '0;
            r_oor   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_drain <= n_drain;
            r_oor   <= n_oor;
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_oor   = r_oor;

    `ASSERT_NEXT(a_oor_direct, i_clk, i_rst_n, (r_state == S_IDLE) && i_oor && !i_go, r_state == S_OUT)
    `ASSERT_IMP(a_idle_quiet, i_clk, i_rst_n, r_state == S_IDLE, !o_out_valid)
    `ASSERT_NEXT(a_fin_out, i_clk, i_rst_n, r_state == S_FIN, o_out_valid && !o_out_oor)
endmodule

[hw/rtl/clamped_window_convolution_core.sv]
// Clamped window convolution over a stored height map: top level.
// Uses the input stream tdata: [1:0] cmd, [9:2] pos_x, [17:10] pos_y,
// [23:18] coef_index, [39:24] value. Output tdata: [15:0] filtered;
// tuser: out_of_range. Writes to pixel and coefficient stores give no
// result. A compute request walks the dim x dim window (9 to 49 taps) one
// tap per cycle through the pixel and coefficient RAM read ports, drains
// the two-stage multiply-accumulate, runs a bit-serial rounding divider
// (a load, then one step per quotient bit) and latches the result before
// o_m_tvalid rises. One compute is in flight at a time; the input is not
// ready until its result is transferred. An out-of-range compute gives its
// result in the cycle after acceptance. A stalled receiver holds the result
// stable. Reset sets width and height to 0, kernel_dim to 3, average mode
// on, and the controller to idle; the stores are undefined until written.
// Configuration is by APB, registers at 0x0, 0x4, 0x8, 0xC.
// Depends on cwc_pkg, cwc_ctrl, cwc_datapath, cwc_ram.
module clamped_window_convolution_core import cwc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // cmd, pos_x, pos_y, coef_index, value
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // filtered
    output logic        o_m_tuser,   // out_of_range
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    // configuration registers
    logic [8:0] r_width, r_height;
    logic [2:0] r_kdim;
    logic       r_avg;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= '0; r_height <= '0; r_kdim <= 3'd3; r_avg <= 1'b1;
        end else if (psel && penable && pwrite) begin
            case (paddr)
                REG_WIDTH:  r_width  <= pwdata[8:0];
                REG_HEIGHT: r_height <= pwdata[8:0];
                REG_KDIM:   r_kdim   <= pwdata[2:0];
                REG_AVG:    r_avg    <= pwdata[0];
                default: ;
            endcase
        end
    end
    assign pready = 1'b1;
    always_comb begin
        case (paddr)
            REG_WIDTH:  prdata = {23'b0, r_width};
            REG_HEIGHT: prdata = {23'b0, r_height};
            REG_KDIM:   prdata = {29'b0, r_kdim};
            REG_AVG:    prdata = {31'b0, r_avg};
            default: prdata = '0;
        endcase
    end

    // input decode
    logic [1:0]  cmd;
    logic [7:0]  px, py;
    logic [5:0]  ci;
    logic [15:0] val;
    assign cmd = i_s_tdata[1:0];
    assign px  = i_s_tdata[9:2];
    assign py  = i_s_tdata[17:10];
    assign ci  = i_s_tdata[23:18];
    assign val = i_s_tdata[39:24];

    logic busy, acc, inrange;
    assign o_s_tready = !busy;
    assign acc = i_s_tvalid && o_s_tready;
    assign inrange = (r_width != 0) && (r_height != 0) &&
                     ({1'b0, px} < r_width) && ({1'b0, py} < r_height);

    t_dp_cmd dcmd;
    t_dp_sts dsts;
    cwc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_go(acc && cmd == CMD_COMP && inrange),
        .i_oor(acc && cmd == CMD_COMP && !inrange),
        .i_sts(dsts), .i_out_taken(i_m_tready),
        .o_cmd(dcmd), .o_busy(busy), .o_out_valid(o_m_tvalid), .o_out_oor(o_m_tuser));

    logic [15:0] filt;
    cwc_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(dcmd), .o_sts(dsts),
        .i_pix_we(acc && cmd == CMD_PIX),
        .i_coef_we(acc && cmd == CMD_COEF && ci < 6'(COEF_DEPTH)),
        .i_pos_x(px), .i_pos_y(py), .i_coef_index(ci), .i_value(val),
        .i_width(r_width), .i_height(r_height), .i_kdim(r_kdim), .i_avg(r_avg),
        .o_filtered(filt));
    assign o_m_tdata = o_m_tuser ? 16'd0 : filt;
endmodule
